// ===== sv/pinhole_camera_ray_generator_unit_assert.svh =====
// Assertion macros for the pinhole camera ray generator.
`ifndef PINHOLE_CAMERA_RAY_GENERATOR_UNIT_ASSERT_SVH
`define PINHOLE_CAMERA_RAY_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PCRG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PCRG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pcrg_pkg.sv =====
// Shared constants, types and helper functions of the ray generator.
package pcrg_pkg;

  localparam int PIXEL_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int DIM_W = 13;
  localparam int TAN_W = 20;
  localparam int POS_W = 24;
  localparam int CFG_W = 24;
  localparam int IDX_W = 3;
  localparam int TG_W  = 32;
  // magnitude width of a clamped film point component (up to 2^30)
  localparam int NORM_TG_MW = 31;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [TAN_W-1:0] TAN_RST    = 20'd20662;

  localparam logic signed [63:0] TG_LIM = 64'sd1073741824;

  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_HALF_FOV_TAN = 3'd2,
    REG_CAM_POS_X    = 3'd3,
    REG_CAM_POS_Y    = 3'd4,
    REG_CAM_POS_Z    = 3'd5
  } cfg_reg_t;

  // cycles through pcrg_div for an nw-bit numerator
  function automatic int div_lat(input int nw);
    return nw + 2;
  endfunction

  // cycles through pcrg_norm for mw-bit magnitudes
  function automatic int norm_lat(input int mw, input int f);
    return 2 * mw + f + 7;
  endfunction

  // divide by 2^sh, round to nearest, halves away from zero
  function automatic logic signed [63:0] rshr(input logic signed [63:0] x, input int sh);
    logic [63:0] mag;
    logic [63:0] q;
    mag = x[63] ? 64'(-x) : 64'(x);
    q = (mag + (64'd1 << (sh - 1))) >> sh;
    return x[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [63:0] sat(input logic signed [63:0] x,
                                             input logic signed [63:0] lo,
                                             input logic signed [63:0] hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

endpackage

// ===== sv/pcrg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, rounds to nearest.
module pcrg_div #(
  parameter int NW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic          neg,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          neg_o,
  output logic [NW:0]   quo
);
  import pcrg_pkg::*;

  localparam int AW = NW + 1;

  // wk shifts numerator bits out at the top and quotient bits in at the bottom
  logic [AW-1:0] wk [0:AW];
  logic [DW-1:0] rm [0:AW];
  logic [DW-1:0] dv [0:AW];
  logic          sg [0:AW];
  logic          ge [1:AW];
  logic [DW-1:0] rm_next [1:AW];

  always_comb begin
    logic [DW:0] t;
    t = '0;
    for (int k = 1; k <= AW; k++) begin
      t = {rm[k-1], wk[k-1][AW-1]};
      ge[k] = (t >= {1'b0, dv[k-1]});
      rm_next[k] = ge[k] ? DW'(t - {1'b0, dv[k-1]}) : t[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wk[0] <= AW'(num) + AW'(den >> 1);
      rm[0] <= '0;
      dv[0] <= den;
      sg[0] <= neg;
      for (int k = 1; k <= AW; k++) begin
        wk[k] <= {wk[k-1][AW-2:0], ge[k]};
        rm[k] <= rm_next[k];
        dv[k] <= dv[k-1];
        sg[k] <= sg[k-1];
      end
    end
  end

  assign quo   = wk[AW];
  assign neg_o = sg[AW];

endmodule

// ===== sv/pcrg_norm.sv =====
// Pipelined 3-vector normalize: squares, sum, digit-by-digit sqrt, three dividers.
module pcrg_norm #(
  parameter int MW        = 31,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [MW:0]          vin  [3],
  output logic signed [FRAC_BITS+1:0] vout [3]
);
  import pcrg_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int OW  = F + 2;
  localparam int RW  = MW + 1;
  localparam int SW  = 2 * RW;
  localparam int RMW = RW + 3;
  localparam int NW  = MW + F;
  localparam int DLY = 2 + RW;
  localparam logic [NW:0] ONE_Q = {{NW{1'b0}}, 1'b1} << F;

  logic [MW-1:0]   mag_a [3];
  logic            neg_a [3];
  logic [2*MW-1:0] sq_b  [3];
  logic [MW-1:0]   mag_d [0:DLY-1][3];
  logic            neg_d [0:DLY-1][3];

  logic [RMW-1:0] rem_q  [0:RW];
  logic [RW-1:0]  root_q [0:RW];
  logic [SW-1:0]  rest_q [0:RW];
  logic [RMW-1:0] rem_next  [1:RW];
  logic           bit_next  [1:RW];

  logic [RW-1:0] len;
  logic [NW:0]   quo   [3];
  logic          neg_q [3];

  // one root bit per stage
  always_comb begin
    logic [RMW-1:0] t;
    logic [RMW-1:0] tr;
    t = '0;
    tr = '0;
    for (int k = 1; k <= RW; k++) begin
      t = {rem_q[k-1][RMW-3:0], rest_q[k-1][SW-1:SW-2]};
      tr = RMW'({root_q[k-1], 2'b01});
      bit_next[k] = (t >= tr);
      rem_next[k] = bit_next[k] ? t - tr : t;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg_a[i] <= vin[i][MW];
        mag_a[i] <= vin[i][MW] ? MW'(-vin[i]) : MW'(vin[i]);
        sq_b[i]  <= mag_a[i] * mag_a[i];
      end
      mag_d[0] <= mag_a;
      neg_d[0] <= neg_a;
      for (int k = 1; k < DLY; k++) begin
        mag_d[k] <= mag_d[k-1];
        neg_d[k] <= neg_d[k-1];
      end
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      rest_q[0] <= SW'(sq_b[0]) + SW'(sq_b[1]) + SW'(sq_b[2]);
      for (int k = 1; k <= RW; k++) begin
        rem_q[k]  <= rem_next[k];
        root_q[k] <= {root_q[k-1][RW-2:0], bit_next[k]};
        rest_q[k] <= rest_q[k-1] << 2;
      end
      for (int i = 0; i < 3; i++) begin
        if (quo[i] > ONE_Q) begin
          vout[i] <= neg_q[i] ? -OW'(ONE_Q) : OW'(ONE_Q);
        end else begin
          vout[i] <= neg_q[i] ? -OW'(quo[i]) : OW'(quo[i]);
        end
      end
    end
  end

  // zero vector: numerators are zero too, so dividing by one gives zero
  assign len = (root_q[RW] == '0) ? RW'(1) : root_q[RW];

  for (genvar i = 0; i < 3; i++) begin : g_div
    pcrg_div #(
      .NW(NW),
      .DW(RW)
    ) u_div (
      .clk  (clk),
      .en   (en),
      .neg  (neg_d[DLY-1][i]),
      .num  ({mag_d[DLY-1][i], {F{1'b0}}}),
      .den  (len),
      .neg_o(neg_q[i]),
      .quo  (quo[i])
    );
  end

endmodule

// ===== sv/pinhole_camera_ray_generator_unit.sv =====
// Pinhole camera primary ray generator, fully pipelined top level.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------
//   cfg      | cfg_wr              | cfg_index, cfg_data
//   in       | in_valid / in_stall | pixel_col, pixel_row, jitter_x/y, lens_u/v
//   out      | out_valid/out_stall | ray_org_x/y/z, ray_dir_x/y/z
//
// One item per clock while no result is held by out_stall; the valid line spans the
// whole pipeline, whose length is set by the film divider (div_lat) and three
// normalize pipelines (norm_lat) in series.
// A result held by out_stall freezes every stage together and raises in_stall in
// that cycle; out_stall with no result waiting has no effect.
// Reset clears the valid line and loads the register reset values.
`include "pinhole_camera_ray_generator_unit_assert.svh"

module pinhole_camera_ray_generator_unit #(
  parameter int PIXEL_BITS = pcrg_pkg::PIXEL_BITS_DEF,
  parameter int FRAC_BITS  = pcrg_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr,
  input  logic [pcrg_pkg::IDX_W-1:0]  cfg_index,
  input  logic [pcrg_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [PIXEL_BITS-1:0]       pixel_col,
  input  logic [PIXEL_BITS-1:0]       pixel_row,
  input  logic [FRAC_BITS-1:0]        jitter_x,
  input  logic [FRAC_BITS-1:0]        jitter_y,
  input  logic [FRAC_BITS-1:0]        lens_u,
  input  logic [FRAC_BITS-1:0]        lens_v,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [FRAC_BITS+1:0] ray_org_x,
  output logic signed [FRAC_BITS+1:0] ray_org_y,
  output logic signed [FRAC_BITS+1:0] ray_org_z,
  output logic signed [FRAC_BITS+1:0] ray_dir_x,
  output logic signed [FRAC_BITS+1:0] ray_dir_y,
  output logic signed [FRAC_BITS+1:0] ray_dir_z
);
  import pcrg_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int OW  = F + 2;
  localparam int AW  = (PIXEL_BITS + 3 > 15) ? PIXEL_BITS + 3 : 15;
  localparam int PW  = AW + TAN_W + 1;
  localparam int DNW = PW - 1;
  localparam int LD  = div_lat(DNW);
  localparam int K0  = LD + 4;
  localparam int LN1 = norm_lat(NORM_TG_MW, F);
  localparam int KF  = K0 + LN1;
  localparam int LN2 = norm_lat(F + 1, F);
  localparam int KR  = KF + LN2;
  localparam int LN3 = norm_lat(F + 2, F);
  localparam int KU  = KR + 2 + LN3;
  localparam int LAT = KU + 3;
  localparam int PRW = 2 * OW;
  localparam int UVW = F + 1 + OW;

  localparam logic signed [OW-1:0]   ONE_S  = OW'(1) << F;
  localparam logic signed [TG_W-1:0] NEG_ONE_TG = -(TG_W'(1) << F);
  localparam logic signed [63:0]     ORG_HI = (64'sd2 <<< F) - 64'sd1;
  localparam logic signed [63:0]     ORG_LO = -(64'sd2 <<< F);

  // configuration registers
  logic [DIM_W-1:0]        img_w;
  logic [DIM_W-1:0]        img_h;
  logic [TAN_W-1:0]        tan_h;
  logic signed [POS_W-1:0] cam [3];
  logic [DIM_W-1:0]        wq;
  logic [DIM_W-1:0]        hq;

  logic           en;
  logic [LAT-1:0] vld;

  logic [PIXEL_BITS-1:0]   col0, row0;
  logic [F-1:0]            jx0, jy0, jx1, jy1, jx2, jy2;
  logic [F-1:0]            u0, v0;
  logic [F-1:0]            ud [0:KU-1];
  logic [F-1:0]            vd [0:KU-1];
  logic signed [AW-1:0]    ax1, ay1;
  logic [DIM_W-1:0]        w1, h1, w2, h2;
  logic signed [PW-1:0]    px2, py2;

  logic [DNW:0] q_x1, q_x2, q_y1, q_y2;
  logic         n_x1, n_x2, n_y1, n_y2;
  logic signed [63:0] sx, sy;

  logic signed [TG_W-1:0] tg  [3];
  logic signed [TG_W-1:0] tgd [3];
  logic signed [TG_W-1:0] dv  [3];

  logic signed [OW-1:0]  dir_n [3];
  logic signed [OW-1:0]  fw    [3];
  logic signed [OW-1:0]  rr    [3];
  logic signed [OW-1:0]  rt    [3];
  logic signed [OW:0]    upr   [3];
  logic signed [OW-1:0]  up    [3];
  logic signed [OW-1:0]  dird  [0:KU-KF][3];
  logic signed [OW-1:0]  fwd   [0:LN2-1][3];
  logic signed [OW-1:0]  rtd   [0:LN3+1][3];
  logic signed [PRW-1:0] pr    [6];
  logic signed [UVW-1:0] pu    [3];
  logic signed [UVW-1:0] pv    [3];
  logic signed [OW-1:0]  org   [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= WIDTH_RST;
      img_h <= HEIGHT_RST;
      tan_h <= TAN_RST;
      cam[0] <= '0;
      cam[1] <= '0;
      cam[2] <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  img_w  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: img_h  <= cfg_data[DIM_W-1:0];
        REG_HALF_FOV_TAN: tan_h  <= cfg_data[TAN_W-1:0];
        REG_CAM_POS_X:    cam[0] <= $signed(cfg_data[POS_W-1:0]);
        REG_CAM_POS_Y:    cam[1] <= $signed(cfg_data[POS_W-1:0]);
        REG_CAM_POS_Z:    cam[2] <= $signed(cfg_data[POS_W-1:0]);
        default: ;
      endcase
    end
  end

  // a zero size acts as one
  assign wq = (img_w == '0) ? DIM_W'(1) : img_w;
  assign hq = (img_h == '0) ? DIM_W'(1) : img_h;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // film point numerators: 2c+1-W and H-2r-1, times the tangent
  always_ff @(posedge clk) begin
    if (en) begin
      col0 <= pixel_col;
      row0 <= pixel_row;
      jx0  <= jitter_x;
      jy0  <= jitter_y;
      u0   <= lens_u;
      v0   <= lens_v;

      ax1 <= $signed({{(AW-PIXEL_BITS-1){1'b0}}, col0, 1'b1}) - $signed(AW'(wq));
      ay1 <= $signed(AW'(hq)) - $signed({{(AW-PIXEL_BITS-1){1'b0}}, row0, 1'b1});
      w1  <= wq;
      h1  <= hq;
      jx1 <= jx0;
      jy1 <= jy0;

      px2 <= ax1 * $signed({1'b0, tan_h});
      py2 <= ay1 * $signed({1'b0, tan_h});
      w2  <= w1;
      h2  <= h1;
      jx2 <= jx1;
      jy2 <= jy1;
    end
  end

  pcrg_div #(.NW(DNW), .DW(DIM_W)) u_div_x1 (
    .clk(clk), .en(en), .neg(px2[PW-1]),
    .num(px2[PW-1] ? DNW'(-px2) : DNW'(px2)), .den(h2),
    .neg_o(n_x1), .quo(q_x1)
  );
  pcrg_div #(.NW(DNW), .DW(DIM_W)) u_div_x2 (
    .clk(clk), .en(en), .neg(1'b0), .num(DNW'(jx2)), .den(w2),
    .neg_o(n_x2), .quo(q_x2)
  );
  pcrg_div #(.NW(DNW), .DW(DIM_W)) u_div_y1 (
    .clk(clk), .en(en), .neg(py2[PW-1]),
    .num(py2[PW-1] ? DNW'(-py2) : DNW'(py2)), .den(h2),
    .neg_o(n_y1), .quo(q_y1)
  );
  pcrg_div #(.NW(DNW), .DW(DIM_W)) u_div_y2 (
    .clk(clk), .en(en), .neg(1'b0), .num(DNW'(jy2)), .den(h2),
    .neg_o(n_y2), .quo(q_y2)
  );

  // each term is rounded on its own before the add
  always_comb begin
    sx = (n_x1 ? -$signed(64'(q_x1)) : $signed(64'(q_x1)))
       + (n_x2 ? -$signed(64'(q_x2)) : $signed(64'(q_x2)));
    sy = (n_y1 ? -$signed(64'(q_y1)) : $signed(64'(q_y1)))
       + (n_y2 ? -$signed(64'(q_y2)) : $signed(64'(q_y2)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tg[0] <= TG_W'(sat(sx, -TG_LIM, TG_LIM));
      tg[1] <= TG_W'(sat(sy, -TG_LIM, TG_LIM));
      tg[2] <= NEG_ONE_TG;
      for (int i = 0; i < 3; i++) begin
        tgd[i] <= tg[i];
        dv[i]  <= TG_W'(sat(64'(tg[i]) - 64'(cam[i]), -TG_LIM, TG_LIM));
      end
    end
  end

  pcrg_norm #(.MW(NORM_TG_MW), .FRAC_BITS(F)) u_norm_dir (
    .clk(clk), .en(en), .vin(dv), .vout(dir_n)
  );
  pcrg_norm #(.MW(NORM_TG_MW), .FRAC_BITS(F)) u_norm_fwd (
    .clk(clk), .en(en), .vin(tgd), .vout(fw)
  );

  // (0,1,0) x forward
  assign rr[0] = fw[2];
  assign rr[1] = '0;
  assign rr[2] = -fw[0];

  pcrg_norm #(.MW(F + 1), .FRAC_BITS(F)) u_norm_right (
    .clk(clk), .en(en), .vin(rr), .vout(rt)
  );

  // forward x right, then origin products
  always_ff @(posedge clk) begin
    if (en) begin
      fwd[0] <= fw;
      for (int k = 1; k < LN2; k++) fwd[k] <= fwd[k-1];
      rtd[0] <= rt;
      for (int k = 1; k < LN3 + 2; k++) rtd[k] <= rtd[k-1];
      dird[0] <= dir_n;
      for (int k = 1; k <= KU - KF; k++) dird[k] <= dird[k-1];
      ud[0] <= u0;
      vd[0] <= v0;
      for (int k = 1; k < KU; k++) begin
        ud[k] <= ud[k-1];
        vd[k] <= vd[k-1];
      end

      pr[0] <= fwd[LN2-1][1] * rt[2];
      pr[1] <= fwd[LN2-1][2] * rt[1];
      pr[2] <= fwd[LN2-1][2] * rt[0];
      pr[3] <= fwd[LN2-1][0] * rt[2];
      pr[4] <= fwd[LN2-1][0] * rt[1];
      pr[5] <= fwd[LN2-1][1] * rt[0];
      upr[0] <= (OW+1)'(rshr(64'(pr[0]) - 64'(pr[1]), F));
      upr[1] <= (OW+1)'(rshr(64'(pr[2]) - 64'(pr[3]), F));
      upr[2] <= (OW+1)'(rshr(64'(pr[4]) - 64'(pr[5]), F));

      for (int i = 0; i < 3; i++) begin
        pu[i] <= $signed({1'b0, ud[KU-1]}) * rtd[LN3+1][i];
        pv[i] <= $signed({1'b0, vd[KU-1]}) * up[i];
      end
    end
  end

  pcrg_norm #(.MW(F + 2), .FRAC_BITS(F)) u_norm_up (
    .clk(clk), .en(en), .vin(upr), .vout(up)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      org[i] = OW'(sat(rshr(64'(pu[i]) + 64'(pv[i]), F), ORG_LO, ORG_HI));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray_org_x <= org[0];
      ray_org_y <= org[1];
      ray_org_z <= org[2];
      ray_dir_x <= dird[KU-KF][0];
      ray_dir_y <= dird[KU-KF][1];
      ray_dir_z <= dird[KU-KF][2];
    end
  end

  `PCRG_ASSERT_NXT(a_freeze, out_valid && out_stall, $stable(vld),
                   "valid line moved during output stall")
  `PCRG_ASSERT_NXT(a_advance, !(out_valid && out_stall) && vld[LAT-2], out_valid,
                   "item dropped before output register")
  `PCRG_ASSERT_IMP(a_dir_unit, out_valid,
                   ray_dir_x >= -ONE_S && ray_dir_x <= ONE_S &&
                   ray_dir_y >= -ONE_S && ray_dir_y <= ONE_S &&
                   ray_dir_z >= -ONE_S && ray_dir_z <= ONE_S,
                   "direction component outside unit range")

endmodule
